### hw/rtl/awsk_pkg.sv
// ============================================================================
// awsk_pkg
// Shared types and constants for the articulated wheel speed kinematics block.
// ============================================================================
package awsk_pkg;

    // register indexes of the configuration port (byte address = 4 * index)
    localparam logic [2:0] REG_WHEEL_RADIUS    = 3'd0;
    localparam logic [2:0] REG_TRACK_WIDTH     = 3'd1;
    localparam logic [2:0] REG_FRONT_LENGTH    = 3'd2;
    localparam logic [2:0] REG_REAR_LENGTH     = 3'd3;
    localparam logic [2:0] REG_ANGLE_THRESHOLD = 3'd4;

    localparam logic [15:0] WHEEL_RADIUS_RST    = 16'd3072;
    localparam logic [15:0] TRACK_WIDTH_RST     = 16'd6144;
    localparam logic [15:0] FRONT_LENGTH_RST    = 16'd6144;
    localparam logic [15:0] REAR_LENGTH_RST     = 16'd6009;
    localparam logic [14:0] ANGLE_THRESHOLD_RST = 15'd819;

    // pi and 2*pi in Q3.13
    localparam logic [15:0] PI_Q13     = 16'd25736;
    localparam logic [16:0] TWO_PI_Q13 = 17'd51472;

    // register stages of the sine/cosine unit
    localparam int TRIG_LAT = 7;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    // data that rides alongside the trig unit
    typedef struct packed {
        logic signed [15:0] speed;
        logic               turn;
        logic signed [15:0] joint_cmd;
    } trig_side_t;

    // data that rides alongside the divider
    typedef struct packed {
        logic [3:0]         neg;
        logic               fault;
        logic signed [15:0] joint_cmd;
    } div_side_t;

endpackage

### hw/rtl/awsk_trig.sv
// ============================================================================
// awsk_trig
// Pipelined sine and cosine of a Q3.13 angle from a quarter-wave Q14 table.
// ============================================================================
module awsk_trig
    import awsk_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [15:0] angle,
    output logic               out_valid,
    output logic signed [15:0] sin_out,
    output logic signed [15:0] cos_out
);

    localparam int IW = $clog2(DEPTH + 1);
    localparam int XW = IW + 19;
    localparam int KW = 17;
    localparam int PW = XW - 15;
    localparam logic [KW-1:0] RECIP = KW'((64'd1 << 32) / TWO_PI_Q13);

    // quarter-wave sine table, built from a truncated taylor series
    logic [14:0] sin_rom [DEPTH+1];

    for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
        localparam logic [63:0] X  = (64'(k) * 64'd1686629713) / DEPTH;
        localparam logic [63:0] T1 = ((((X  * X) >> 30) * X) >> 30) / 6;
        localparam logic [63:0] T2 = ((((T1 * X) >> 30) * X) >> 30) / 20;
        localparam logic [63:0] T3 = ((((T2 * X) >> 30) * X) >> 30) / 42;
        localparam logic [63:0] T4 = ((((T3 * X) >> 30) * X) >> 30) / 72;
        localparam logic [63:0] T5 = ((((T4 * X) >> 30) * X) >> 30) / 110;
        localparam logic [63:0] T6 = ((((T5 * X) >> 30) * X) >> 30) / 156;
        localparam logic [63:0] T7 = ((((T6 * X) >> 30) * X) >> 30) / 210;
        localparam logic [63:0] T8 = ((((T7 * X) >> 30) * X) >> 30) / 272;
        localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                               + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7)
                               + longint'(T8);
        localparam longint SCL = (SUM < 0) ? 0 : SUM;
        localparam longint RND = (SCL + 32768) >>> 16;
        localparam longint VAL = (RND > 16384) ? 16384 : RND;
        assign sin_rom[k] = 15'(VAL);
    end

    logic [TRIG_LAT-1:0] vld_reg;

    logic [XW-1:0]    x1_reg, x2_reg;
    logic [XW+KW-1:0] prod2_reg;
    logic [PW-1:0]    q3_reg, p4_reg;
    logic [16:0]      r3_reg;
    quad_t            quad5_reg, quad6_reg;
    logic [IW-1:0]    idx5_reg;
    logic [14:0]      ts6_reg, tc6_reg;
    logic [5:0]       neg_reg;
    logic signed [15:0] sin7_reg, cos7_reg;

    logic [15:0]      mag;
    logic [XW-1:0]    x_next;
    logic [PW-1:0]    q0;
    logic [XW+1:0]    qc;
    logic [16:0]      r_next;
    logic [PW-1:0]    p_next;
    quad_t            quad_next;
    logic [IW-1:0]    idx_next;
    logic signed [15:0] ts_s, tc_s, s_q, c_q, sin_next, cos_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TRIG_LAT-2:0], in_valid};
        end
    end

    // table position: round(4*DEPTH*|a| / (2*pi)) by reciprocal multiply
    always_comb begin
        mag    = angle[15] ? (~angle + 16'd1) : angle;
        x_next = XW'(mag) * XW'(4 * DEPTH) + XW'(PI_Q13);
        q0     = prod2_reg[XW+KW-1:32];
        qc     = (XW+2)'(q0) * (XW+2)'(TWO_PI_Q13);
        r_next = 17'({2'b00, x2_reg} - qc);
        p_next = q3_reg + PW'(r3_reg >= TWO_PI_Q13);
        if (p4_reg < PW'(DEPTH)) begin
            quad_next = QUAD_0;
            idx_next  = IW'(p4_reg);
        end else if (p4_reg < PW'(2 * DEPTH)) begin
            quad_next = QUAD_1;
            idx_next  = IW'(p4_reg - PW'(DEPTH));
        end else if (p4_reg < PW'(3 * DEPTH)) begin
            quad_next = QUAD_2;
            idx_next  = IW'(p4_reg - PW'(2 * DEPTH));
        end else begin
            quad_next = QUAD_3;
            idx_next  = IW'(p4_reg - PW'(3 * DEPTH));
        end
        ts_s = {1'b0, ts6_reg};
        tc_s = {1'b0, tc6_reg};
        case (quad6_reg)
            QUAD_0: begin
                s_q = ts_s;
                c_q = tc_s;
            end
            QUAD_1: begin
                s_q = tc_s;
                c_q = -ts_s;
            end
            QUAD_2: begin
                s_q = -ts_s;
                c_q = -tc_s;
            end
            QUAD_3: begin
                s_q = -tc_s;
                c_q = ts_s;
            end
            default: begin
                s_q = ts_s;
                c_q = tc_s;
            end
        endcase
        sin_next = neg_reg[5] ? -s_q : s_q;
        cos_next = c_q;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= x_next;
            x2_reg    <= x1_reg;
            prod2_reg <= (XW+KW)'(x1_reg) * (XW+KW)'(RECIP);
            q3_reg    <= q0;
            r3_reg    <= r_next;
            p4_reg    <= p_next;
            quad5_reg <= quad_next;
            idx5_reg  <= idx_next;
            quad6_reg <= quad5_reg;
            ts6_reg   <= sin_rom[idx5_reg];
            tc6_reg   <= sin_rom[IW'(DEPTH) - idx5_reg];
            sin7_reg  <= sin_next;
            cos7_reg  <= cos_next;
            neg_reg   <= {neg_reg[4:0], angle[15]};
        end
    end

    assign out_valid = vld_reg[TRIG_LAT-1];
    assign sin_out   = sin7_reg;
    assign cos_out   = cos7_reg;

`ifndef SYNTHESIS
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (sin_out <= 16'sd16384 && sin_out >= -16'sd16384 &&
                       cos_out <= 16'sd16384 && cos_out >= -16'sd16384))
        else $error("trig output outside unit range");
`endif

endmodule

### hw/rtl/awsk_div.sv
// ============================================================================
// awsk_div
// Pipelined restoring divider, one quotient bit per stage, several lanes,
// with an overflow flag when the quotient does not fit in QW bits.
// ============================================================================
module awsk_div
    import awsk_pkg::*;
#(
    parameter int NW    = 62,
    parameter int DW    = 49,
    parameter int QW    = 24,
    parameter int LANES = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num [LANES],
    input  logic [DW-1:0] den [LANES],
    output logic          out_valid,
    output logic [QW-1:0] quo [LANES],
    output logic          ovf [LANES]
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [QW:0]    vld_reg;
    logic [CW-1:0]  rem_reg [QW+1][LANES];
    logic [DW-1:0]  den_reg [QW+1][LANES];
    logic [QW-1:0]  quo_reg [QW+1][LANES];
    logic           ovf_reg [QW+1][LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[0][l] <= CW'(num[l]);
                den_reg[0][l] <= den[l];
                quo_reg[0][l] <= '0;
                ovf_reg[0][l] <= CW'(num[l]) >= CW'({den[l], {QW{1'b0}}});
            end
        end

        for (genvar j = 1; j <= QW; j++) begin : g_stage
            logic [CW-1:0] sh;
            logic          ge;
            assign sh = CW'(den_reg[j-1][l]) << (QW - j);
            assign ge = rem_reg[j-1][l] >= sh;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j][l] <= ge ? (rem_reg[j-1][l] - sh) : rem_reg[j-1][l];
                    den_reg[j][l] <= den_reg[j-1][l];
                    ovf_reg[j][l] <= ovf_reg[j-1][l];
                    quo_reg[j][l] <= quo_reg[j-1][l] | (QW'(ge) << (QW - j));
                end
            end
        end

        assign quo[l] = quo_reg[QW][l];
        assign ovf[l] = ovf_reg[QW][l];
    end

    assign out_valid = vld_reg[QW];

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> ((ovf_reg[QW][0] || rem_reg[QW][0] < CW'(den_reg[QW][0])) &&
                       (ovf_reg[QW][LANES-1] ||
                        rem_reg[QW][LANES-1] < CW'(den_reg[QW][LANES-1]))))
        else $error("divider remainder not reduced below divisor");
`endif

endmodule

### hw/rtl/articulated_wheel_speed_kinematics.sv
// ============================================================================
// articulated_wheel_speed_kinematics
// Wheel angular speeds and joint rate command for a two-body articulated
// vehicle, from joint angle, forward speed and yaw rate.
// ============================================================================
// Usage:
//   s_ channel carries one command (joint angle, forward speed, yaw rate) per
//   transaction; m_ channel returns one result per command, in order: four
//   saturated wheel rates, the negated yaw rate and a geometry fault flag.
//   Registers (radius, track width, body lengths, angle threshold) sit on the
//   APB port; the user must write them only while no transaction is in
//   flight, since the block itself does not enforce it.
// Depth: input register, sine/cosine pipeline, geometry g1 to g5, divider
//   (one quotient bit per stage for each of the four wheels), output register.
// Throughput: one transaction per cycle while the output is not stalled.
// Stall: the whole pipeline advances together; while m_valid is high and
//   m_ready is low every stage holds and s_ready is low.
// Reset: aresetn clears all valid bits and loads the register defaults;
//   nothing is in flight afterward.
// ============================================================================
module articulated_wheel_speed_kinematics
    import awsk_pkg::*;
#(
    parameter int TRIG_TABLE_DEPTH = 1024,
    parameter int RATE_WIDTH       = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [15:0]           s_joint_angle,
    input  logic signed [15:0]           s_forward_speed,
    input  logic signed [15:0]           s_yaw_rate,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [RATE_WIDTH-1:0] m_front_left_rate,
    output logic signed [RATE_WIDTH-1:0] m_front_right_rate,
    output logic signed [RATE_WIDTH-1:0] m_rear_left_rate,
    output logic signed [RATE_WIDTH-1:0] m_rear_right_rate,
    output logic signed [15:0]           m_joint_rate_cmd,
    output logic                         m_geometry_fault,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int RW      = RATE_WIDTH;
    localparam int NW      = 62;
    localparam int DW      = 49;
    localparam int DIV_LAT = RW + 1;

    // ---------------------------------------------------------------- config
    logic [15:0] wheel_radius_reg, track_width_reg, front_length_reg, rear_length_reg;
    logic [14:0] angle_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_radius_reg    <= WHEEL_RADIUS_RST;
            track_width_reg     <= TRACK_WIDTH_RST;
            front_length_reg    <= FRONT_LENGTH_RST;
            rear_length_reg     <= REAR_LENGTH_RST;
            angle_threshold_reg <= ANGLE_THRESHOLD_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_WHEEL_RADIUS:    wheel_radius_reg    <= pwdata[15:0];
                REG_TRACK_WIDTH:     track_width_reg     <= pwdata[15:0];
                REG_FRONT_LENGTH:    front_length_reg    <= pwdata[15:0];
                REG_REAR_LENGTH:     rear_length_reg     <= pwdata[15:0];
                REG_ANGLE_THRESHOLD: angle_threshold_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_WHEEL_RADIUS:    prdata = {16'd0, wheel_radius_reg};
            REG_TRACK_WIDTH:     prdata = {16'd0, track_width_reg};
            REG_FRONT_LENGTH:    prdata = {16'd0, front_length_reg};
            REG_REAR_LENGTH:     prdata = {16'd0, rear_length_reg};
            REG_ANGLE_THRESHOLD: prdata = {17'd0, angle_threshold_reg};
            default:             prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------------------------------------------------------- control
    logic en;
    logic out_vld_reg;
    logic in_vld_reg, g1_vld_reg, g2_vld_reg, g3_vld_reg, g4_vld_reg, g5_vld_reg;
    logic trig_vld, div_vld;

    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            g1_vld_reg  <= 1'b0;
            g2_vld_reg  <= 1'b0;
            g3_vld_reg  <= 1'b0;
            g4_vld_reg  <= 1'b0;
            g5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg  <= s_valid;
            g1_vld_reg  <= trig_vld;
            g2_vld_reg  <= g1_vld_reg;
            g3_vld_reg  <= g2_vld_reg;
            g4_vld_reg  <= g3_vld_reg;
            g5_vld_reg  <= g4_vld_reg;
            out_vld_reg <= div_vld;
        end
    end

    // ---------------------------------------------------------------- input
    logic signed [15:0] angle_reg, speed_reg, yaw_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= s_joint_angle;
            speed_reg <= s_forward_speed;
            yaw_reg   <= s_yaw_rate;
        end
    end

    logic [15:0] angle_mag;
    trig_side_t  side_in;

    always_comb begin
        angle_mag         = angle_reg[15] ? (~angle_reg + 16'd1) : angle_reg;
        side_in.speed     = speed_reg;
        side_in.turn      = angle_mag > {1'b0, angle_threshold_reg};
        // negating the most negative yaw rate saturates
        side_in.joint_cmd = (yaw_reg == 16'sh8000) ? 16'sh7fff : -yaw_reg;
    end

    // ---------------------------------------------------------------- trig
    logic signed [15:0] sin_w, cos_w;
    trig_side_t         tside_reg [TRIG_LAT];

    awsk_trig #(
        .DEPTH (TRIG_TABLE_DEPTH)
    ) u_trig (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_vld_reg),
        .angle     (angle_reg),
        .out_valid (trig_vld),
        .sin_out   (sin_w),
        .cos_out   (cos_w)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            tside_reg[0] <= side_in;
            for (int i = 1; i < TRIG_LAT; i++) begin
                tside_reg[i] <= tside_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------- geometry
    // g1: body denominators l1*cos + l2*2^14 and l2*cos + l1*2^14, and width*sin
    logic signed [33:0] den_reg [2];
    logic signed [31:0] ws_reg;
    trig_side_t         g1_side_reg, g2_side_reg;
    logic signed [33:0] cos_x, fl_x, rl_x;
    logic signed [31:0] sin_x, tw_x;

    always_comb begin
        cos_x = {{18{cos_w[15]}}, cos_w};
        fl_x  = {18'd0, front_length_reg};
        rl_x  = {18'd0, rear_length_reg};
        sin_x = {{16{sin_w[15]}}, sin_w};
        tw_x  = {16'd0, track_width_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= fl_x * cos_x + (rl_x <<< 14);
            den_reg[1]  <= rl_x * cos_x + (fl_x <<< 14);
            ws_reg      <= tw_x * sin_x;
            g1_side_reg <= tside_reg[TRIG_LAT-1];
        end
    end

    // g2: wheel numerators, per-body geometry flags and a combined fault
    logic signed [35:0] num_reg [4];
    logic [31:0]        den2_reg [2];
    logic [1:0]         geo_reg;
    logic               g2_fault_reg;
    logic signed [35:0] den36 [2];
    logic signed [35:0] ws36;
    logic [1:0]         den_pos;

    always_comb begin
        ws36 = {{4{ws_reg[31]}}, ws_reg};
        for (int b = 0; b < 2; b++) begin
            den36[b]   = {{2{den_reg[b][33]}}, den_reg[b]};
            den_pos[b] = !den_reg[b][33] && (den_reg[b] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int b = 0; b < 2; b++) begin
                num_reg[2*b]   <= (den36[b] <<< 1) + ws36;
                num_reg[2*b+1] <= (den36[b] <<< 1) - ws36;
                den2_reg[b]    <= {den_reg[b][30:0], 1'b0};
                geo_reg[b]     <= g1_side_reg.turn && den_pos[b];
            end
            g2_fault_reg <= g1_side_reg.turn && !(den_pos[0] && den_pos[1]);
            g2_side_reg  <= g1_side_reg;
        end
    end

    // g3: operand selection, straight case (or a body without a positive denominator) uses factors of one
    logic [32:0]        gmul_reg [4];
    logic [31:0]        fmul_reg [4];
    logic [3:0]         neg3_reg;
    logic [15:0]        vmag3_reg;
    logic               g3_fault_reg;
    logic signed [15:0] g3_cmd_reg;
    logic [15:0]        radius_eff;
    logic signed [15:0] speed2;

    assign speed2     = g2_side_reg.speed;
    assign radius_eff = (wheel_radius_reg == '0) ? 16'd1 : wheel_radius_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int w = 0; w < 4; w++) begin
                if (geo_reg[w/2]) begin
                    gmul_reg[w] <= num_reg[w][35] ? 33'(-num_reg[w]) : 33'(num_reg[w]);
                    fmul_reg[w] <= den2_reg[w/2];
                    neg3_reg[w] <= speed2[15] ^ num_reg[w][35];
                end else begin
                    gmul_reg[w] <= 33'd1;
                    fmul_reg[w] <= 32'd1;
                    neg3_reg[w] <= speed2[15];
                end
            end
            vmag3_reg    <= speed2[15] ? (~speed2 + 16'd1) : speed2;
            g3_fault_reg <= g2_fault_reg;
            g3_cmd_reg   <= g2_side_reg.joint_cmd;
        end
    end

    // g4: numerator and divisor products
    logic [48:0]        nc_reg [4];
    logic [47:0]        df_reg [4];
    logic [3:0]         neg4_reg;
    logic               g4_fault_reg;
    logic signed [15:0] g4_cmd_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int w = 0; w < 4; w++) begin
                nc_reg[w] <= 49'(vmag3_reg) * 49'(gmul_reg[w]);
                df_reg[w] <= 48'(radius_eff) * 48'(fmul_reg[w]);
            end
            neg4_reg     <= neg3_reg;
            g4_fault_reg <= g3_fault_reg;
            g4_cmd_reg   <= g3_cmd_reg;
        end
    end

    // g5: round to nearest as (2|N| + D) / (2D), N carrying the 2^12 scale
    logic [NW-1:0] divnum_reg [4];
    logic [DW-1:0] divden_reg [4];
    div_side_t     g5_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int w = 0; w < 4; w++) begin
                divnum_reg[w] <= {nc_reg[w], 13'd0} + NW'(df_reg[w]);
                divden_reg[w] <= {df_reg[w], 1'b0};
            end
            g5_side_reg.neg       <= neg4_reg;
            g5_side_reg.fault     <= g4_fault_reg;
            g5_side_reg.joint_cmd <= g4_cmd_reg;
        end
    end

    // ---------------------------------------------------------------- divide
    logic [RW-1:0] quo_w [4];
    logic          ovf_w [4];
    div_side_t     dside_reg [DIV_LAT];

    awsk_div #(
        .NW    (NW),
        .DW    (DW),
        .QW    (RW),
        .LANES (4)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g5_vld_reg),
        .num       (divnum_reg),
        .den       (divden_reg),
        .out_valid (div_vld),
        .quo       (quo_w),
        .ovf       (ovf_w)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            dside_reg[0] <= g5_side_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------- output
    localparam logic [RW-1:0] POS_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic [RW-1:0] NEG_MIN = {1'b1, {(RW-1){1'b0}}};

    logic [RW-1:0]      rate_next [4];
    logic [RW-1:0]      rate_reg [4];
    logic signed [15:0] cmd_reg;
    logic               fault_reg;
    div_side_t          dside_last;

    assign dside_last = dside_reg[DIV_LAT-1];

    always_comb begin
        for (int w = 0; w < 4; w++) begin
            if (dside_last.neg[w]) begin
                rate_next[w] = (ovf_w[w] || quo_w[w] > NEG_MIN) ? NEG_MIN : -quo_w[w];
            end else begin
                rate_next[w] = (ovf_w[w] || quo_w[w][RW-1]) ? POS_MAX : quo_w[w];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rate_reg  <= rate_next;
            cmd_reg   <= dside_last.joint_cmd;
            fault_reg <= dside_last.fault;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_front_left_rate  = rate_reg[0];
    assign m_front_right_rate = rate_reg[1];
    assign m_rear_left_rate   = rate_reg[2];
    assign m_rear_right_rate  = rate_reg[3];
    assign m_joint_rate_cmd   = cmd_reg;
    assign m_geometry_fault   = fault_reg;

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable({in_vld_reg, g1_vld_reg, g2_vld_reg, g3_vld_reg,
                         g4_vld_reg, g5_vld_reg, out_vld_reg}))
        else $error("pipeline valid bits moved during stall");

    a_cmd_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_joint_rate_cmd != 16'sh8000)
        else $error("joint rate command reached most negative value");
`endif

endmodule
